@@ rtl/sat_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types, constants and the sigmoid table for the cell transition pipe.
// ----------------------------------------------------------------------------
package sat_pkg;

  // Field and fixed-point formats
  localparam int FieldBits   = 16;
  localparam int FracBits    = 16;
  localparam int LevelBits   = FracBits + 1;          // 0 .. ONE inclusive
  localparam int ProdBits    = 2 * FieldBits;         // gain * magnitude
  localparam int SigDepth    = 1024;
  localparam int SigIdxBits  = $clog2(SigDepth);
  localparam int SatShift    = FracBits + 11;         // product >= 2**SatShift saturates
  localparam int IdxShift    = SatShift - SigIdxBits;
  localparam int CfgIdxBits  = 3;

  localparam logic [LevelBits-1:0] LevelOne  = LevelBits'(1) << FracBits;
  localparam logic [FieldBits-1:0] LevelHalf = FieldBits'(1) << (FracBits - 1);

  // Configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    RegBirthLow  = 3'd0,
    RegBirthHigh = 3'd1,
    RegDeathLow  = 3'd2,
    RegDeathHigh = 3'd3,
    RegInnerGain = 3'd4,
    RegOuterGain = 3'd5
  } cfg_reg_e;

  // Register reset values
  localparam logic [FieldBits-1:0] BirthLowRst  = 16'd18219;
  localparam logic [FieldBits-1:0] BirthHighRst = 16'd23921;
  localparam logic [FieldBits-1:0] DeathLowRst  = 16'd17498;
  localparam logic [FieldBits-1:0] DeathHighRst = 16'd29164;
  localparam logic [FieldBits-1:0] InnerGainRst = 16'd6966;
  localparam logic [FieldBits-1:0] OuterGainRst = 16'd36571;

  // Load strobes for the three stages of one sigmoid unit
  typedef struct packed {
    logic mag_en;
    logic mul_en;
    logic lut_en;
  } sig_ctrl_t;

  typedef logic [FracBits-1:0] sig_rom_t [SigDepth];

  // Shift-subtract division, used only while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Entry k is sig(8k/depth): e^u by series, invert, square three times
  function automatic sig_rom_t build_sig_rom();
    sig_rom_t    rom;
    logic [63:0] u;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] q;
    logic [63:0] den;
    logic [63:0] val;
    logic [63:0] q31;
    q31 = 64'd1 << 31;
    for (int k = 0; k < SigDepth; k++) begin
      u    = 64'(k) << (24 - SigIdxBits);
      sum  = q31;
      term = q31;
      for (int n = 1; n <= 20; n++) begin
        term = udiv64((term * u) >> 24, 64'(n));
        sum  = sum + term;
      end
      q = udiv64(64'd1 << 62, sum);
      for (int s = 0; s < 3; s++) begin
        q = (q * q) >> 31;
      end
      den    = q31 + q;
      val    = udiv64((q31 << FracBits) + (den >> 1), den);
      rom[k] = val[FracBits-1:0];
    end
    return rom;
  endfunction

  localparam sig_rom_t SigRom = build_sig_rom();

endpackage

@@ rtl/smooth_automaton_transition_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smooth_automaton_transition_top
// Continuous life transition rule for one cell per beat.
// ----------------------------------------------------------------------------
// The block takes one cell beat per clock unless in_stall_o is raised, and
// computes its next level in registered stages: three for the inner-fill
// sigmoid (distance, gain multiply, registered table read), one for the bound
// interpolation, three for the two outer-fill sigmoids in parallel, and one
// for the final product and clamp. Every stage loads on its own when it is
// empty or its successor moves, so bubbles close up and a stalled result at
// the output does not block input until all eight stages hold beats.
// Configuration writes are always accepted and should only be issued while
// no beat is in flight.
module smooth_automaton_transition_top
  import sat_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // cell input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [FieldBits-1:0]  inner_fill_i,
  input  logic [FieldBits-1:0]  outer_fill_i,
  // result output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [FieldBits-1:0]  next_level_o,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [FieldBits-1:0]  cfg_data_i
);

  localparam int NumStages = 8;
  localparam int MixBits   = 2 * LevelBits;

  logic [FieldBits-1:0] birth_low_q, birth_high_q, death_low_q, death_high_q;
  logic [FieldBits-1:0] inner_gain_q, outer_gain_q;

  logic [NumStages:1]   valid_q;
  logic [NumStages:1]   en;
  logic [FieldBits-1:0] outer1_q, outer2_q, outer3_q, outer4_q;
  logic [LevelBits-1:0] alive;
  logic [FieldBits-1:0] lo, hi;
  logic [LevelBits-1:0] s_lo, s_hi;
  logic [LevelBits-1:0] keep_w;
  logic [MixBits-1:0]   mix_sum;
  logic [FieldBits-1:0] level_q;
  sig_ctrl_t            inner_ctrl, outer_ctrl;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      birth_low_q  <= BirthLowRst;
      birth_high_q <= BirthHighRst;
      death_low_q  <= DeathLowRst;
      death_high_q <= DeathHighRst;
      inner_gain_q <= InnerGainRst;
      outer_gain_q <= OuterGainRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegBirthLow:  birth_low_q  <= cfg_data_i;
        RegBirthHigh: birth_high_q <= cfg_data_i;
        RegDeathLow:  death_low_q  <= cfg_data_i;
        RegDeathHigh: death_high_q <= cfg_data_i;
        RegInnerGain: inner_gain_q <= cfg_data_i;
        RegOuterGain: outer_gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage load enables: a stage loads when empty or when its successor moves
  always_comb begin
    en[NumStages] = !valid_q[NumStages] || !out_stall_i;
    for (int k = NumStages - 1; k >= 1; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[1];

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[1]) begin
        valid_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Inner-fill aliveness
  assign inner_ctrl = '{mag_en: en[1], mul_en: en[2], lut_en: en[3]};

  sat_sigmoid u_alive (
    .clk_i   (clk_i),
    .ctrl_i  (inner_ctrl),
    .gain_i  (inner_gain_q),
    .x_i     (inner_fill_i),
    .x0_i    (LevelHalf),
    .level_o (alive)
  );

  // Carry the outer fill alongside
  always_ff @(posedge clk_i) begin
    if (en[1]) outer1_q <= outer_fill_i;
    if (en[2]) outer2_q <= outer1_q;
    if (en[3]) outer3_q <= outer2_q;
    if (en[4]) outer4_q <= outer3_q;
  end

  // Interpolated bounds
  sat_blend u_blend (
    .clk_i        (clk_i),
    .en_i         (en[4]),
    .alive_i      (alive),
    .birth_low_i  (birth_low_q),
    .birth_high_i (birth_high_q),
    .death_low_i  (death_low_q),
    .death_high_i (death_high_q),
    .lo_o         (lo),
    .hi_o         (hi)
  );

  // Outer-fill sigmoids against both bounds
  assign outer_ctrl = '{mag_en: en[5], mul_en: en[6], lut_en: en[7]};

  sat_sigmoid u_sig_lo (
    .clk_i   (clk_i),
    .ctrl_i  (outer_ctrl),
    .gain_i  (outer_gain_q),
    .x_i     (outer4_q),
    .x0_i    (lo),
    .level_o (s_lo)
  );

  sat_sigmoid u_sig_hi (
    .clk_i   (clk_i),
    .ctrl_i  (outer_ctrl),
    .gain_i  (outer_gain_q),
    .x_i     (outer4_q),
    .x0_i    (hi),
    .level_o (s_hi)
  );

  // Final product, round and clamp to the field range
  assign keep_w  = LevelOne - s_hi;
  assign mix_sum = MixBits'(s_lo) * MixBits'(keep_w) + MixBits'(LevelHalf);

  always_ff @(posedge clk_i) begin
    if (en[NumStages]) begin
      if (|mix_sum[MixBits-1:FracBits+FieldBits]) begin
        level_q <= '1;
      end else begin
        level_q <= mix_sum[FracBits +: FieldBits];
      end
    end
  end

  assign out_valid_o  = valid_q[NumStages];
  assign next_level_o = level_q;

  // Input is held off only when every stage holds a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input stalled while the pipe has a free stage");

  // An accepted beat lands in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_q[1])
    else $error("accepted beat lost at pipe entry");

  // A free output never backs up into the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while the output drains");

endmodule

@@ rtl/sat_sigmoid.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_sigmoid
// Three-stage sigmoid of gain * (x - x0): magnitude, multiply, table read.
// ----------------------------------------------------------------------------
module sat_sigmoid
  import sat_pkg::*;
(
  input  logic                 clk_i,
  input  sig_ctrl_t            ctrl_i,
  input  logic [FieldBits-1:0] gain_i,
  input  logic [FieldBits-1:0] x_i,
  input  logic [FieldBits-1:0] x0_i,
  output logic [LevelBits-1:0] level_o
);

  logic                 neg1_q, neg2_q, neg3_q;
  logic [FieldBits-1:0] mag_q;
  logic [ProdBits-1:0]  prod_q;
  logic [FracBits-1:0]  rom_q;
  logic                 sat_q;
  logic [LevelBits-1:0] val;

  // Take the signed distance apart into sign and magnitude
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mag_en) begin
      neg1_q <= (x_i < x0_i);
      mag_q  <= (x_i < x0_i) ? (x0_i - x_i) : (x_i - x0_i);
    end
  end

  // Scale by the gain
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      neg2_q <= neg1_q;
      prod_q <= ProdBits'(gain_i) * ProdBits'(mag_q);
    end
  end

  // Read the table, flag arguments beyond its range
  always_ff @(posedge clk_i) begin
    if (ctrl_i.lut_en) begin
      neg3_q <= neg2_q;
      sat_q  <= |prod_q[ProdBits-1:SatShift];
      rom_q  <= SigRom[prod_q[IdxShift +: SigIdxBits]];
    end
  end

  // Mirror for negative arguments
  assign val     = sat_q ? LevelOne : {1'b0, rom_q};
  assign level_o = neg3_q ? (LevelOne - val) : val;

endmodule

@@ rtl/sat_blend.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_blend
// One stage: interpolate the lower and upper outer-fill bounds by aliveness.
// ----------------------------------------------------------------------------
module sat_blend
  import sat_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [LevelBits-1:0] alive_i,
  input  logic [FieldBits-1:0] birth_low_i,
  input  logic [FieldBits-1:0] birth_high_i,
  input  logic [FieldBits-1:0] death_low_i,
  input  logic [FieldBits-1:0] death_high_i,
  output logic [FieldBits-1:0] lo_o,
  output logic [FieldBits-1:0] hi_o
);

  localparam int SumBits = LevelBits + FieldBits + 1;

  logic [LevelBits-1:0] dead_w;
  logic [SumBits-1:0]   lo_sum, hi_sum;
  logic [FieldBits-1:0] lo_q, hi_q;

  // Weighted sums with round to nearest
  assign dead_w = LevelOne - alive_i;
  assign lo_sum = SumBits'(dead_w) * SumBits'(birth_low_i)
                + SumBits'(alive_i) * SumBits'(death_low_i)
                + SumBits'(LevelHalf);
  assign hi_sum = SumBits'(dead_w) * SumBits'(birth_high_i)
                + SumBits'(alive_i) * SumBits'(death_high_i)
                + SumBits'(LevelHalf);

  // Hold bounds for the outer sigmoids
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q <= lo_sum[FracBits +: FieldBits];
      hi_q <= hi_sum[FracBits +: FieldBits];
    end
  end

  assign lo_o = lo_q;
  assign hi_o = hi_q;

endmodule

@@ bench/smooth_automaton_transition_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smooth_automaton_transition_top_tb
// Self-checking bench for the continuous life transition rule.
// ----------------------------------------------------------------------------
// Cells go in through the valid/stall input channel and every accepted cell
// gets its next level predicted from a local copy of the rule registers and a
// locally built sigmoid table. Results are checked in order against those
// predictions. Named tests cover the reset settings, ignored register
// indexes, saturation and clamping, misordered bounds, random settings,
// a long output hold-off and a final stretch at full rate.
// ----------------------------------------------------------------------------
module smooth_automaton_transition_top_tb
  import sat_pkg::*;
();

  localparam int              TableDepth    = 1024;
  localparam int              FracW         = 16;
  localparam logic [63:0]     OneLevel      = 64'd1 << FracW;
  localparam logic [15:0]     MaxLevel      = 16'hFFFF;
  localparam logic [15:0]     HalfFill      = 16'h8000;
  localparam int              WatchdogLimit = 2000;
  localparam int              DrainCycles   = 16;
  localparam int              HoldOffCycles = 60;

  // Register indexes past the end of the list
  localparam logic [CfgIdxBits-1:0] RegPastListLow  = 3'd6;
  localparam logic [CfgIdxBits-1:0] RegPastListHigh = 3'd7;

  typedef struct {
    logic [15:0] birth_low;
    logic [15:0] birth_high;
    logic [15:0] death_low;
    logic [15:0] death_high;
    logic [15:0] inner_gain;
    logic [15:0] outer_gain;
  } rule_regs_t;

  typedef struct {
    logic [15:0] inner_fill;
    logic [15:0] outer_fill;
    logic [15:0] level;
  } pending_cell_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic [FieldBits-1:0]  inner_fill_i = '0;
  logic [FieldBits-1:0]  outer_fill_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic [FieldBits-1:0]  next_level_o;
  logic                  cfg_valid_i  = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_index_i  = '0;
  logic [FieldBits-1:0]  cfg_data_i   = '0;

  logic [15:0]   sigmoid_table [TableDepth];
  rule_regs_t    rule_regs;
  pending_cell_t pending_cells [$];
  pending_cell_t oldest_cell;
  int            error_count       = 0;
  int            idle_cycles       = 0;
  int            hold_off_left     = 0;
  int            stall_burst_left  = 0;
  bit            sender_gaps_on    = 1'b1;
  bit            receiver_gaps_on  = 1'b1;

  smooth_automaton_transition_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .inner_fill_i(inner_fill_i),
    .outer_fill_i(outer_fill_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .next_level_o(next_level_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Rule prediction
  // ---------------------------------------------------------------------------

  // Entry k holds sig(8k/depth): e^u by series, invert, square three times
  function automatic void build_sigmoid_table();
    logic [63:0] u;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] inv;
    logic [63:0] den;
    for (int k = 0; k < TableDepth; k++) begin
      u    = (64'(k) << 24) / TableDepth;
      sum  = 64'd1 << 31;
      term = 64'd1 << 31;
      for (int n = 1; n <= 20; n++) begin
        term = ((term * u) >> 24) / 64'(n);
        sum  = sum + term;
      end
      inv = (64'd1 << 62) / sum;
      for (int s = 0; s < 3; s++) begin
        inv = (inv * inv) >> 31;
      end
      den = (64'd1 << 31) + inv;
      sigmoid_table[k] = 16'((((64'd1 << 31) << FracW) + den / 2) / den);
    end
  endfunction

  // Sigmoid of gain * (x - x0); saturates once the index runs off the table
  function automatic logic [16:0] sigmoid_at(input logic [15:0] gain, input logic [15:0] x,
                                            input logic [15:0] x0);
    logic        below;
    logic [15:0] span;
    logic [63:0] idx;
    logic [63:0] level;
    below = x < x0;
    span  = below ? x0 - x : x - x0;
    idx   = ((64'(gain) * 64'(span)) * TableDepth) >> (FracW + 11);
    level = (idx >= TableDepth) ? OneLevel : 64'(sigmoid_table[idx[9:0]]);
    return 17'(below ? OneLevel - level : level);
  endfunction

  function automatic logic [15:0] blend_bound(input logic [15:0] birth, input logic [15:0] death,
                                             input logic [16:0] alive);
    return 16'(((OneLevel - 64'(alive)) * 64'(birth) + 64'(alive) * 64'(death)
                + OneLevel / 2) >> FracW);
  endfunction

  function automatic logic [15:0] predict_next_level(input logic [15:0] inner,
                                                     input logic [15:0] outer);
    logic [16:0] alive;
    logic [16:0] rise;
    logic [16:0] fall;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [63:0] level;
    alive = sigmoid_at(rule_regs.inner_gain, inner, HalfFill);
    lo    = blend_bound(rule_regs.birth_low, rule_regs.death_low, alive);
    hi    = blend_bound(rule_regs.birth_high, rule_regs.death_high, alive);
    rise  = sigmoid_at(rule_regs.outer_gain, outer, lo);
    fall  = sigmoid_at(rule_regs.outer_gain, outer, hi);
    level = (64'(rise) * (OneLevel - 64'(fall)) + OneLevel / 2) >> FracW;
    return (level > 64'(MaxLevel)) ? MaxLevel : level[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Offer one cell beat, with an optional idle burst ahead of it
  task automatic send_cell(input logic [15:0] inner, input logic [15:0] outer);
    pending_cell_t sent_cell;
    int            gap;
    gap = 0;
    if (sender_gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    inner_fill_i <= inner;
    outer_fill_i <= outer;
    do @(posedge clk_i); while (in_stall_o);
    sent_cell.inner_fill = inner;
    sent_cell.outer_fill = outer;
    sent_cell.level      = predict_next_level(inner, outer);
    pending_cells.push_back(sent_cell);
  endtask

  // Drop valid and hold until every predicted level has come back
  task automatic drain_cells();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxBits-1:0] index, input logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      RegBirthLow:  rule_regs.birth_low  = value;
      RegBirthHigh: rule_regs.birth_high = value;
      RegDeathLow:  rule_regs.death_low  = value;
      RegDeathHigh: rule_regs.death_high = value;
      RegInnerGain: rule_regs.inner_gain = value;
      RegOuterGain: rule_regs.outer_gain = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_rule(input logic [15:0] birth_low, input logic [15:0] birth_high,
                            input logic [15:0] death_low, input logic [15:0] death_high,
                            input logic [15:0] inner_gain, input logic [15:0] outer_gain);
    write_register(RegBirthLow, birth_low);
    write_register(RegBirthHigh, birth_high);
    write_register(RegDeathLow, death_low);
    write_register(RegDeathHigh, death_high);
    write_register(RegInnerGain, inner_gain);
    write_register(RegOuterGain, outer_gain);
  endtask

  // ---------------------------------------------------------------------------
  // Random values
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] pick_bound();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return MaxLevel;
      2:       return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(12000, 36000));
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return MaxLevel;
      2:       return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1024, 40000));
    endcase
  endfunction

  function automatic logic [15:0] near_fill(input logic [15:0] center, input int spread);
    int v;
    v = int'(center) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  // Mostly cells that land near the current bounds, the rest anywhere
  task automatic send_random_cell();
    logic [15:0] inner;
    logic [15:0] outer;
    inner = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 65535))
                                        : near_fill(HalfFill, 6000);
    case ($urandom_range(0, 4))
      0: outer = near_fill(rule_regs.birth_low, 3000);
      1: outer = near_fill(rule_regs.birth_high, 3000);
      2: outer = near_fill(rule_regs.death_low, 3000);
      3: outer = near_fill(rule_regs.death_high, 3000);
      default: outer = 16'($urandom_range(0, 65535));
    endcase
    send_cell(inner, outer);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Cells straight after reset run on the reset rule
  task automatic test_reset_rule();
    send_cell(16'h0000, 16'h0000);
    send_cell(16'hFFFF, 16'hFFFF);
    send_cell(16'h0000, 16'hFFFF);
    send_cell(16'hFFFF, 16'h0000);
    send_cell(HalfFill, 16'd20000);
    send_cell(16'd40000, 16'd21000);
    send_cell(16'd25000, 16'd19000);
    send_cell(16'h7FFF, 16'd26000);
    send_cell(16'h5555, 16'hAAAA);
    drain_cells();
  endtask

  // Writes past the register list must leave the rule alone
  task automatic test_ignored_index();
    write_register(RegPastListLow, 16'($urandom_range(0, 65535)));
    write_register(RegPastListHigh, 16'($urandom_range(0, 65535)));
    send_cell(HalfFill, 16'd20000);
    send_cell(16'hAAAA, 16'h5555);
    send_cell(16'd30000, 16'd24000);
    drain_cells();
  endtask

  // Saturated sigmoids and a product of exactly one, which must clamp
  task automatic test_saturation();
    write_rule(16'h0000, MaxLevel, 16'h0000, MaxLevel, MaxLevel, MaxLevel);
    send_cell(HalfFill, HalfFill);
    send_cell(16'h0000, 16'h0001);
    send_cell(16'hFFFF, 16'hFFFE);
    send_cell(16'hFFFF, 16'hFFFF);
    send_cell(16'h0000, 16'h0000);
    drain_cells();
  endtask

  // Lower bounds above upper bounds, and zero gains, run unchanged
  task automatic test_misordered_bounds();
    write_rule(16'd40000, 16'd10000, 16'd45000, 16'd12000, 16'd6966, 16'd36571);
    send_cell(16'h0000, 16'd25000);
    send_cell(16'hFFFF, 16'd25000);
    send_cell(HalfFill, 16'd41000);
    drain_cells();
    write_rule(16'd18219, 16'd23921, 16'd17498, 16'd29164, 16'h0000, 16'h0000);
    send_cell(16'h1234, 16'hFEDC);
    send_cell(16'hFFFF, 16'h0000);
    drain_cells();
  endtask

  // Several random rules, the all-zero and all-one rules among them
  task automatic test_random_rules();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_rule('0, '0, '0, '0, '0, '0);
        1: write_rule(MaxLevel, MaxLevel, MaxLevel, MaxLevel, MaxLevel, MaxLevel);
        default: write_rule(pick_bound(), pick_bound(), pick_bound(), pick_bound(),
                            pick_gain(), pick_gain());
      endcase
      sender_gaps_on   = (phase % 3) != 2;
      receiver_gaps_on = (phase % 3) != 1;
      repeat (200) send_random_cell();
      drain_cells();
    end
    sender_gaps_on   = 1'b1;
    receiver_gaps_on = 1'b1;
  endtask

  // Hold the output off long enough to fill the pipe and stall the input
  task automatic test_output_hold_off();
    write_rule(16'd18219, 16'd23921, 16'd17498, 16'd29164, 16'd6966, 16'd36571);
    sender_gaps_on = 1'b0;
    @(posedge clk_i);
    hold_off_left = HoldOffCycles;
    repeat (40) send_random_cell();
    drain_cells();
    sender_gaps_on = 1'b1;
  endtask

  // Last stretch back to back on both sides
  task automatic test_full_rate();
    write_rule(pick_bound(), pick_bound(), pick_bound(), pick_bound(), pick_gain(), pick_gain());
    sender_gaps_on   = 1'b0;
    receiver_gaps_on = 1'b0;
    repeat (300) send_random_cell();
    drain_cells();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    build_sigmoid_table();
    rule_regs.birth_low  = BirthLowRst;
    rule_regs.birth_high = BirthHighRst;
    rule_regs.death_low  = DeathLowRst;
    rule_regs.death_high = DeathHighRst;
    rule_regs.inner_gain = InnerGainRst;
    rule_regs.outer_gain = OuterGainRst;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_rule();
    test_ignored_index();
    test_saturation();
    test_misordered_bounds();
    test_random_rules();
    test_output_hold_off();
    test_full_rate();

    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Output stall: a requested hold-off first, then random bursts
  always @(negedge clk_i) begin
    if (hold_off_left > 0) begin
      out_stall_i   <= 1'b1;
      hold_off_left  = hold_off_left - 1;
    end else if (stall_burst_left > 0) begin
      out_stall_i      <= 1'b1;
      stall_burst_left  = stall_burst_left - 1;
    end else if (receiver_gaps_on && $urandom_range(0, 4) == 0) begin
      out_stall_i      <= 1'b1;
      stall_burst_left  = $urandom_range(0, 4);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_cells.size() == 0) begin
        $display("%0t: unexpected next_level beat: expected none, actual %0d",
                 $time, next_level_o);
        error_count++;
      end else begin
        oldest_cell = pending_cells.pop_front();
        if (next_level_o !== oldest_cell.level) begin
          $display("%0t: next_level mismatch (inner %0d outer %0d): expected %0d, actual %0d",
                   $time, oldest_cell.inner_fill, oldest_cell.outer_fill,
                   oldest_cell.level, next_level_o);
          error_count++;
        end
      end
    end
  end

  // Advance the idle count on cycles that move no beat on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule
